// ===== rtl/core/cbc_pkg.sv =====
// cbc_pkg: shared types, codes and helpers for the cartridge bank controller
// no dependencies; imported by the channel interfaces and the top level

package cbc_pkg;

    // payload widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int BANK_W  = 9;
    localparam int RBANK_W = 4;
    localparam int RTC_W   = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    // controller kinds
    typedef enum logic [2:0] {
        KIND_ROM_ONLY = 3'd0,
        KIND_MBC1     = 3'd1,
        KIND_MBC2     = 3'd2,
        KIND_MBC3     = 3'd3,
        KIND_MBC5     = 3'd4
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND       = 2'd0,
        CFG_HAS_RAM    = 2'd1,
        CFG_ROM_SIZE   = 2'd2,
        CFG_RAM_SINGLE = 2'd3
    } cfg_idx_t;

    // 8 KB regions of the control area, from address bits 14:13
    typedef enum logic [1:0] {
        REG_RAM_ENABLE = 2'd0,
        REG_ROM_BANK   = 2'd1,
        REG_RAM_BANK   = 2'd2,
        REG_MODE_LATCH = 2'd3
    } region_t;

    localparam logic [3:0] ENABLE_CODE   = 4'hA;
    localparam logic [7:0] MBC3_RAM_MAX  = 8'h03;
    localparam logic [7:0] MBC5_RAM_MAX  = 8'h0F;
    localparam logic [7:0] RTC_FIRST     = 8'h08;
    localparam logic [7:0] RTC_LAST      = 8'h0C;
    localparam int         MBC1_UPPER_SHIFT = 5;

    // bank registers kept across writes
    typedef struct packed {
        logic                ram_enable;
        logic [7:0]          rom_low;
        logic                rom_high;
        logic [RBANK_W-1:0]  ram_bank;
        logic                mode;
    } bank_state_t;

    // rom bank mask 2^(code+1)-1, saturating at nine bits
    function automatic logic [BANK_W-1:0] rom_mask(input logic [CFG_W-1:0] code);
        logic [BANK_W-1:0] m;
        unique case (code)
            4'd0:    m = 9'h001;
            4'd1:    m = 9'h003;
            4'd2:    m = 9'h007;
            4'd3:    m = 9'h00F;
            4'd4:    m = 9'h01F;
            4'd5:    m = 9'h03F;
            4'd6:    m = 9'h07F;
            4'd7:    m = 9'h0FF;
            default: m = 9'h1FF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/cbc_if.sv =====
// cbc_if: valid/ready channels carrying cpu writes in and bank mappings out
// depends on cbc_pkg for payload widths

interface cbc_in_if;
    import cbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output write_addr, output write_data, input ready);
    modport sink   (input valid, input write_addr, input write_data, output ready);
endinterface

interface cbc_out_if;
    import cbc_pkg::*;

    logic               valid;
    logic               ready;
    logic               ram_enabled;
    logic [BANK_W-1:0]  low_rom_bank;
    logic [BANK_W-1:0]  high_rom_bank;
    logic [RBANK_W-1:0] ram_bank;
    logic               rtc_select_valid;
    logic [RTC_W-1:0]   rtc_select_index;
    logic               rtc_latch_pulse;

    modport source (output valid, output ram_enabled, output low_rom_bank,
                    output high_rom_bank, output ram_bank, output rtc_select_valid,
                    output rtc_select_index, output rtc_latch_pulse, input ready);
    modport sink   (input valid, input ram_enabled, input low_rom_bank,
                    input high_rom_bank, input ram_bank, input rtc_select_valid,
                    input rtc_select_index, input rtc_latch_pulse, output ready);
endinterface

// ===== rtl/core/cartridge_bank_controller_top.sv =====
// cartridge_bank_controller_top: bank controller for mbc1/mbc2/mbc3/mbc5 carts
// depends on cbc_pkg and the channel interfaces in cbc_if.sv

// Each cpu write transaction on in_ch updates the bank registers of the
// configured controller kind and produces one transaction on out_ch with the
// mappings in force after the write. One write per cycle unless out_ch stalls;
// the result appears, registered, in the cycle after acceptance. The input
// stays ready whenever the output register is empty or being drained, so a
// stalled consumer stops intake only while its result waits. The user writes
// the configuration port only while no transaction is in flight (unenforced).

module cartridge_bank_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_W-1:0]      cfg_wdata,
    cbc_in_if.sink                         in_ch,
    cbc_out_if.source                      out_ch
);
    import cbc_pkg::*;

    // configuration registers
    logic [2:0]       kind_reg;
    logic             has_ram_reg;
    logic [CFG_W-1:0] rom_size_reg;
    logic             ram_single_reg;

    // bank state and output register
    bank_state_t        st_reg, st_next;
    logic               out_valid_reg;
    logic               ram_enabled_reg, ram_enabled_next;
    logic [BANK_W-1:0]  low_bank_reg, low_bank_next;
    logic [BANK_W-1:0]  high_bank_reg, high_bank_next;
    logic [RBANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic               sel_valid_reg, sel_valid_next;
    logic [RTC_W-1:0]   sel_index_reg, sel_index_next;
    logic               latch_reg, latch_next;

    logic               in_accept;
    logic [BANK_W-1:0]  rm;
    logic [RBANK_W-1:0] ram_m;
    logic               in_area;
    logic               is_enable;
    region_t            region;
    logic [7:0]         wd;
    logic [BANK_W-1:0]  upper;

    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign in_accept   = in_ch.valid & in_ch.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_ROM_ONLY;
            has_ram_reg    <= 1'b0;
            rom_size_reg   <= '0;
            ram_single_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KIND:       kind_reg       <= cfg_wdata[2:0];
                CFG_HAS_RAM:    has_ram_reg    <= cfg_wdata[0];
                CFG_ROM_SIZE:   rom_size_reg   <= cfg_wdata;
                CFG_RAM_SINGLE: ram_single_reg <= cfg_wdata[0];
                default:        kind_reg       <= kind_reg;
            endcase
        end
    end

    // address decode and masks
    assign wd        = in_ch.write_data;
    assign in_area   = ~in_ch.write_addr[15];
    assign region    = region_t'(in_ch.write_addr[14:13]);
    assign is_enable = (wd[3:0] == ENABLE_CODE);
    assign rm        = rom_mask(rom_size_reg);
    assign ram_m     = ram_single_reg ? 4'd0 : 4'd3;

    // next bank state for the selected kind
    always_comb
    begin
        st_next        = st_reg;
        sel_valid_next = 1'b0;
        sel_index_next = '0;
        latch_next     = 1'b0;
        if (in_area)
        begin
            unique case (kind_reg)
                KIND_MBC1:
                begin
                    unique case (region)
                        REG_RAM_ENABLE: st_next.ram_enable = is_enable & has_ram_reg;
                        REG_ROM_BANK:   st_next.rom_low =
                            (wd[4:0] == 5'd0) ? 8'd1 : {3'd0, wd[4:0]};
                        REG_RAM_BANK:   st_next.ram_bank = {2'd0, wd[1:0]};
                        REG_MODE_LATCH: st_next.mode = wd[0];
                        default:        st_next = st_reg;
                    endcase
                end
                KIND_MBC2:
                begin
                    if (!in_ch.write_addr[14])
                    begin
                        if (in_ch.write_addr[8])
                            st_next.rom_low = (wd[3:0] == 4'd0) ? 8'd1 : {4'd0, wd[3:0]};
                        else
                            st_next.ram_enable = is_enable;
                    end
                end
                KIND_MBC3:
                begin
                    unique case (region)
                        REG_RAM_ENABLE: st_next.ram_enable = is_enable;
                        REG_ROM_BANK:   st_next.rom_low =
                            (wd[6:0] == 7'd0) ? 8'd1 : {1'b0, wd[6:0]};
                        REG_RAM_BANK:
                        begin
                            if (wd <= MBC3_RAM_MAX)
                                st_next.ram_bank = wd[RBANK_W-1:0];
                            else if (wd >= RTC_FIRST && wd <= RTC_LAST)
                            begin
                                // 8..12 minus 8 is just the low three bits
                                sel_valid_next = 1'b1;
                                sel_index_next = wd[RTC_W-1:0];
                            end
                        end
                        REG_MODE_LATCH: latch_next = 1'b1;
                        default:        st_next = st_reg;
                    endcase
                end
                KIND_MBC5:
                begin
                    unique case (region)
                        REG_RAM_ENABLE: st_next.ram_enable = is_enable;
                        REG_ROM_BANK:
                        begin
                            if (in_ch.write_addr[12])
                                st_next.rom_high = wd[0];
                            else
                                st_next.rom_low = wd;
                        end
                        REG_RAM_BANK:
                        begin
                            if (wd <= MBC5_RAM_MAX)
                                st_next.ram_bank = wd[RBANK_W-1:0];
                        end
                        REG_MODE_LATCH: st_next = st_reg;
                        default:        st_next = st_reg;
                    endcase
                end
                default: st_next = st_reg;
            endcase
        end
    end

    // mappings from the updated state
    assign upper = {st_next.ram_bank, {MBC1_UPPER_SHIFT{1'b0}}};

    always_comb
    begin
        ram_enabled_next = st_next.ram_enable;
        low_bank_next    = '0;
        high_bank_next   = 9'd1;
        ram_bank_next    = '0;
        unique case (kind_reg)
            KIND_MBC1:
            begin
                low_bank_next  = st_next.mode ? (upper & rm) : '0;
                high_bank_next = (upper | {1'b0, st_next.rom_low}) & rm;
                ram_bank_next  = st_next.mode ? (st_next.ram_bank & ram_m) : '0;
            end
            KIND_MBC2:
                high_bank_next = {1'b0, st_next.rom_low} & rm;
            KIND_MBC3:
            begin
                high_bank_next = {1'b0, st_next.rom_low} & rm;
                ram_bank_next  = st_next.ram_bank & ram_m;
            end
            KIND_MBC5:
            begin
                high_bank_next = {st_next.rom_high, st_next.rom_low} & rm;
                ram_bank_next  = st_next.ram_bank & ram_m;
            end
            default: high_bank_next = 9'd1;
        endcase
    end

    // bank state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.ram_enable <= 1'b0;
            st_reg.rom_low    <= 8'd1;
            st_reg.rom_high   <= 1'b0;
            st_reg.ram_bank   <= '0;
            st_reg.mode       <= 1'b0;
        end
        else if (in_accept)
        begin
            st_reg <= st_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ram_enabled_reg <= ram_enabled_next;
            low_bank_reg    <= low_bank_next;
            high_bank_reg   <= high_bank_next;
            ram_bank_reg    <= ram_bank_next;
            sel_valid_reg   <= sel_valid_next;
            sel_index_reg   <= sel_index_next;
            latch_reg       <= latch_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.ram_enabled      = ram_enabled_reg;
    assign out_ch.low_rom_bank     = low_bank_reg;
    assign out_ch.high_rom_bank    = high_bank_reg;
    assign out_ch.ram_bank         = ram_bank_reg;
    assign out_ch.rtc_select_valid = sel_valid_reg;
    assign out_ch.rtc_select_index = sel_index_reg;
    assign out_ch.rtc_latch_pulse  = latch_reg;

endmodule
